// ===== hdl/integer_to_roman_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral encoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while
// arst_n is asserted.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH
`define INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2R_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2R_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/i2r_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral encoder: package
// Symbol table, shared types and the greedy symbol selection function.
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

	localparam int VALUE_W     = 12;
	localparam int CHAR_W      = 7;
	localparam int NUM_SYMBOLS = 13;
	localparam int SYM_IDX_W   = $clog2(NUM_SYMBOLS);

	localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

	// Depth of the queue between the front and back ends.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// ASCII codes of the numeral letters.
	localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;
	localparam logic [CHAR_W-1:0] CHAR_I    = 7'h49;
	localparam logic [CHAR_W-1:0] CHAR_V    = 7'h56;
	localparam logic [CHAR_W-1:0] CHAR_X    = 7'h58;
	localparam logic [CHAR_W-1:0] CHAR_L    = 7'h4C;
	localparam logic [CHAR_W-1:0] CHAR_C    = 7'h43;
	localparam logic [CHAR_W-1:0] CHAR_D    = 7'h44;
	localparam logic [CHAR_W-1:0] CHAR_M    = 7'h4D;

	// Symbol values from largest to smallest.
	localparam logic [VALUE_W-1:0] SYM_VALUE [NUM_SYMBOLS] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};

	// First letter of each symbol.
	localparam logic [CHAR_W-1:0] SYM_FIRST [NUM_SYMBOLS] = '{
		CHAR_M, CHAR_C, CHAR_D, CHAR_C, CHAR_C, CHAR_X, CHAR_L,
		CHAR_X, CHAR_X, CHAR_I, CHAR_V, CHAR_I, CHAR_I
	};

	// Second letter of each symbol, CHAR_NONE for one-letter symbols.
	localparam logic [CHAR_W-1:0] SYM_SECOND [NUM_SYMBOLS] = '{
		CHAR_NONE, CHAR_M, CHAR_NONE, CHAR_D, CHAR_NONE, CHAR_C, CHAR_NONE,
		CHAR_L, CHAR_NONE, CHAR_X, CHAR_NONE, CHAR_V, CHAR_NONE
	};

	// One classified transaction as it travels from front to back.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               err;
	} q_item_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Encoder sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_SECOND
	} back_state_t;

	// Largest symbol whose value fits in rem. The compares are independent;
	// the lowest index that fits wins.
	function automatic logic [SYM_IDX_W-1:0] sym_pick(input logic [VALUE_W-1:0] rem);
		logic [SYM_IDX_W-1:0] pick;
		pick = SYM_IDX_W'(NUM_SYMBOLS - 1);
		for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
			if (rem >= SYM_VALUE[i]) begin
				pick = SYM_IDX_W'(i);
			end
		end
		return pick;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/i2r_front.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral encoder: front end
// Accepts input transactions, flags out-of-range values and hands the
// classified item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [i2r_pkg::VALUE_W-1:0]   value,
	input  logic                          push,
	output logic                          full,
	input  i2r_pkg::q_status_t            q_stat,
	output logic                          q_push,
	output i2r_pkg::q_item_t              q_wr_item
);
	import i2r_pkg::*;

	logic    valid_s1;
	q_item_t item_s1;
	logic    accept;
	logic    load_s1;

	// The stage drains into the queue whenever the queue has room.
	assign q_push    = valid_s1 && !q_stat.full;
	assign q_wr_item = item_s1;
	assign full      = valid_s1 && q_stat.full;
	assign accept    = push && !full;
	assign load_s1   = !valid_s1 || q_push;

	// Stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= accept;
		end
	end

	// Capture the value and classify it as out of range or not.
	always_ff @(posedge clk) begin
		if (load_s1 && accept) begin
			item_s1.value <= value;
			item_s1.err   <= (value == '0) || (value > MAX_VALUE);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/i2r_queue.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral encoder: decoupling queue
// A short register queue that lets the front and back ends stall
// independently of each other.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_push,
	input  i2r_pkg::q_item_t    q_wr_item,
	input  logic                q_pop,
	output i2r_pkg::q_item_t    q_rd_item,
	output i2r_pkg::q_status_t  q_stat
);
	import i2r_pkg::*;

	q_item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push      = q_push && !q_stat.full;
	assign do_pop       = q_pop && !q_stat.empty;
	assign q_rd_item    = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= q_wr_item;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/i2r_back.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral encoder: back end
// Takes classified items from the queue and emits the numeral one letter
// per cycle into the result register while it is free or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2r_pkg::q_status_t            q_stat,
	input  i2r_pkg::q_item_t              q_rd_item,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [i2r_pkg::CHAR_W-1:0]    character,
	output logic                          last,
	output logic                          error
);
	import i2r_pkg::*;

	back_state_t          state_q;
	back_state_t          state_n;
	logic [VALUE_W-1:0]   rem_q;
	logic [CHAR_W-1:0]    sec_char_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;
	logic                 err_q;

	logic                 adv;
	logic [VALUE_W-1:0]   src_rem;
	logic [SYM_IDX_W-1:0] sym_idx;
	logic [VALUE_W-1:0]   rem_n;
	logic                 two_letter;
	logic                 step_en;
	logic [CHAR_W-1:0]    res_char;
	logic                 res_last;
	logic                 res_err;

	// The result register advances when it is free or being taken.
	assign adv   = !out_valid_q || pop;
	assign empty = !out_valid_q;

	// Greedy symbol choice on the remainder of the current value.
	always_comb begin
		src_rem    = (state_q == ST_IDLE) ? q_rd_item.value : rem_q;
		sym_idx    = sym_pick(src_rem);
		rem_n      = src_rem - SYM_VALUE[sym_idx];
		two_letter = (SYM_SECOND[sym_idx] != CHAR_NONE);
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty && adv) begin
					if (q_rd_item.err) begin
						state_n = ST_IDLE;
					end else if (two_letter) begin
						state_n = ST_SECOND;
					end else begin
						state_n = (rem_n == '0) ? ST_IDLE : ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (adv) begin
					if (two_letter) begin
						state_n = ST_SECOND;
					end else begin
						state_n = (rem_n == '0) ? ST_IDLE : ST_RUN;
					end
				end
			end
			ST_SECOND: begin
				if (adv) begin
					state_n = (rem_q == '0) ? ST_IDLE : ST_RUN;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: the letter produced this cycle.
	always_comb begin
		step_en  = 1'b0;
		q_pop    = 1'b0;
		res_char = SYM_FIRST[sym_idx];
		res_last = !two_letter && (rem_n == '0);
		res_err  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				step_en = !q_stat.empty && adv;
				q_pop   = step_en;
				if (q_rd_item.err) begin
					res_char = CHAR_NONE;
					res_last = 1'b1;
					res_err  = 1'b1;
				end
			end
			ST_RUN: begin
				step_en = adv;
			end
			ST_SECOND: begin
				step_en  = adv;
				res_char = sec_char_q;
				res_last = (rem_q == '0);
			end
			default: begin
				step_en = 1'b0;
			end
		endcase
	end

	// Sequencer state and result register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (adv) begin
				out_valid_q <= step_en;
			end
		end
	end

	// Remainder, pending second letter and result payload.
	always_ff @(posedge clk) begin
		if (step_en && (state_q != ST_SECOND)) begin
			rem_q      <= rem_n;
			sec_char_q <= SYM_SECOND[sym_idx];
		end
		if (step_en) begin
			char_q <= res_char;
			last_q <= res_last;
			err_q  <= res_err;
		end
	end

	assign character = char_q;
	assign last      = last_q;
	assign error     = err_q;

endmodule

`default_nettype wire

// ===== hdl/integer_to_roman_encoder.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral encoder: top level
// Converts 12-bit integers to Roman numerals, one ASCII letter per result.
// ----------------------------------------------------------------------------
// Each input transaction carries a value; the block returns its Roman numeral
// as a run of result transactions, one ASCII letter each, largest symbol
// first, with last set on the final letter. A value of 0 or above 3999 gives
// a single result with character 0, last 1 and error 1. Both sides behave
// like a queue: push is taken while full is low, and the oldest result sits
// on the result ports while empty is low until pop takes it. The back-end
// sequencer emits one letter per cycle while the result register is free
// or being taken; a numeral has 1 to 15 letters, the most for 3888, and an
// out-of-range value gives one result. The earliest letter passes through
// the input stage and a queue entry before the result register. An input
// stage and a two-entry queue let up to three further values be accepted
// while a numeral is still being emitted or a result waits to be taken.
`default_nettype none

module integer_to_roman_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [i2r_pkg::VALUE_W-1:0]   value,
	input  logic                          push,
	output logic                          full,
	output logic [i2r_pkg::CHAR_W-1:0]    character,
	output logic                          last,
	output logic                          error,
	output logic                          empty,
	input  logic                          pop
);
	import i2r_pkg::*;

	`include "integer_to_roman_encoder_defines.svh"

	q_status_t q_stat;
	q_item_t   q_wr_item;
	q_item_t   q_rd_item;
	logic      q_push;
	logic      q_pop;

	// Front end: accepts and classifies values.
	i2r_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.push      (push),
		.full      (full),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_wr_item (q_wr_item)
	);

	// Queue between the two ends.
	i2r_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_push    (q_push),
		.q_wr_item (q_wr_item),
		.q_pop     (q_pop),
		.q_rd_item (q_rd_item),
		.q_stat    (q_stat)
	);

	// Back end: emits the letters.
	i2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_rd_item (q_rd_item),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.character (character),
		.last      (last),
		.error     (error)
	);

	// An error result is always a single, empty letter.
	`I2R_ASSERT_SAME(a_err_single, !empty && error, last && (character == CHAR_NONE), "bad error result")

	// A letter result always carries a nonzero code.
	`I2R_ASSERT_SAME(a_letter_code, !empty && !error, character != CHAR_NONE, "null letter code")

	// An accepted transaction moves on to the queue or holds the front stage.
	`I2R_ASSERT_NEXT(a_front_keep, push && !full, q_push || full, "front end dropped a transaction")

	// The back end never takes an item from an empty queue.
	`I2R_ASSERT_SAME(a_pop_nonempty, q_pop, !q_stat.empty, "back end popped an empty queue")

endmodule

`default_nettype wire

// ===== verif/integer_to_roman_encoder_test.sv =====
// ----------------------------------------------------------------------------
// Integer to Roman numeral encoder: testbench
// A queue-fed driver pushes values and a monitor pops letters. Each received
// letter is checked against a greedy encoding computed here when the value
// is accepted. Both sides idle at random in the first two thirds of the
// run, and once the receiver holds off long enough for the block to fill up.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_roman_encoder_test;

	localparam int VW = i2r_pkg::VALUE_W;
	localparam int CW = i2r_pkg::CHAR_W;

	localparam int          SYMBOL_COUNT  = 13;
	localparam int unsigned TOP_VALUE     = 3999;
	localparam logic [7:0]  NO_LETTER     = 8'd0;
	localparam int          RANDOM_ITEMS  = 125;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          DRAIN_CYCLES  = 40;
	localparam int          CYCLE_LIMIT   = 200000;

	// Weights and letters of the numeral symbols, largest first.
	localparam int unsigned SYMBOL_WEIGHT [SYMBOL_COUNT] = '{
		1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
	};
	localparam logic [7:0] SYMBOL_HEAD [SYMBOL_COUNT] = '{
		"M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
	};
	localparam logic [7:0] SYMBOL_TAIL [SYMBOL_COUNT] = '{
		NO_LETTER, "M", NO_LETTER, "D", NO_LETTER, "C", NO_LETTER,
		"L", NO_LETTER, "X", NO_LETTER, "V", NO_LETTER
	};

	// One letter of a numeral as it should leave the block.
	typedef struct packed {
		logic [CW-1:0] letter;
		logic          final_letter;
		logic          bad_value;
	} letter_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic [VW-1:0] value     = '0;
	logic          push      = 1'b0;
	logic          full;
	logic [CW-1:0] character;
	logic          last;
	logic          error;
	logic          empty;
	logic          pop       = 1'b0;

	logic [VW-1:0] value_backlog [$];
	letter_t       letters_due   [$];

	int unsigned total_values   = 0;
	int unsigned values_taken   = 0;
	int unsigned letters_seen   = 0;
	int unsigned bad_values     = 0;
	int unsigned full_stalls    = 0;
	int unsigned failures       = 0;
	int unsigned cycle_count    = 0;

	integer_to_roman_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.push      (push),
		.full      (full),
		.character (character),
		.last      (last),
		.error     (error),
		.empty     (empty),
		.pop       (pop)
	);

	// Free-running clock.
	always #6 clk = ~clk;

	// Greedy encoding of one value, appended to the letters still due.
	function automatic void queue_numeral(input logic [VW-1:0] v);
		letter_t     run [$];
		letter_t     one;
		int unsigned rest;
		rest = v;
		if (v == 0 || v > TOP_VALUE) begin
			one.letter       = NO_LETTER[CW-1:0];
			one.final_letter = 1'b1;
			one.bad_value    = 1'b1;
			letters_due.push_back(one);
			return;
		end
		for (int s = 0; s < SYMBOL_COUNT; s++) begin
			while (rest >= SYMBOL_WEIGHT[s]) begin
				rest = rest - SYMBOL_WEIGHT[s];
				one.final_letter = 1'b0;
				one.bad_value    = 1'b0;
				one.letter       = SYMBOL_HEAD[s][CW-1:0];
				run.push_back(one);
				if (SYMBOL_TAIL[s] != NO_LETTER) begin
					one.letter = SYMBOL_TAIL[s][CW-1:0];
					run.push_back(one);
				end
			end
		end
		run[run.size() - 1].final_letter = 1'b1;
		foreach (run[i]) letters_due.push_back(run[i]);
	endfunction

	// Idle percentage for either side in the current third of the run.
	function automatic int unsigned idle_percent(input bit sender);
		if (values_taken < total_values / 3) return sender ? 10 : 71;
		if (values_taken < (2 * total_values) / 3) return sender ? 71 : 10;
		return 0;
	endfunction

	// Driver: records each accepted transaction and offers the next value.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && full) begin
				full_stalls <= full_stalls + 1;
			end else begin
				if (push) begin
					queue_numeral(value);
					values_taken <= values_taken + 1;
					if (value == 0 || value > TOP_VALUE) bad_values <= bad_values + 1;
				end
				if (value_backlog.size() != 0 && $urandom_range(99) >= idle_percent(1'b1)) begin
					value <= value_backlog.pop_front();
					push  <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each popped letter and decides whether to pop next cycle.
	int unsigned hold_left    = 0;
	bit          hold_started = 1'b0;

	always @(posedge clk) begin
		letter_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				letters_seen <= letters_seen + 1;
				if (letters_due.size() == 0) begin
					$display("%0t: unexpected letter char %h last %b error %b", $time,
						character, last, error);
					failures <= failures + 1;
				end else begin
					want = letters_due.pop_front();
					if (character !== want.letter || last !== want.final_letter ||
						error !== want.bad_value) begin
						$display("%0t: expected char %h last %b error %b, got char %h last %b error %b",
							$time, want.letter, want.final_letter, want.bad_value,
							character, last, error);
						failures <= failures + 1;
					end
				end
			end
			// One long hold-off halfway through lets the block fill up.
			if (!hold_started && total_values != 0 && values_taken >= total_values / 2) begin
				hold_started = 1'b1;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= idle_percent(1'b0));
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("integer_to_roman_encoder: mismatch");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [VW-1:0] directed [] = '{
			12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
			12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000,
			12'd2048, 12'd1365, 12'd2730, 12'd1994, 12'd444, 12'd3, 12'd14,
			12'd3000, 12'd1234
		};
		int unsigned pick;
		foreach (directed[i]) value_backlog.push_back(directed[i]);
		// Mostly legal values, with zero and the range above the top mixed in.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(99);
			if (pick < 5) value_backlog.push_back('0);
			else if (pick < 15) value_backlog.push_back(VW'($urandom_range(4095, 4000)));
			else value_backlog.push_back(VW'($urandom_range(TOP_VALUE, 1)));
		end
		total_values = value_backlog.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (value_backlog.size() != 0 || push) @(posedge clk);
		while (letters_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Encoded %0d values (%0d out of range) into %0d letters.",
			values_taken, bad_values, letters_seen);
		$display("Input stalled on full for %0d cycles; %0d failures.", full_stalls, failures);
		if (failures == 0) begin
			$display("integer_to_roman_encoder: match");
		end else begin
			$display("integer_to_roman_encoder: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/i2r_pkg.sv
hdl/i2r_front.sv
hdl/i2r_queue.sv
hdl/i2r_back.sv
hdl/integer_to_roman_encoder.sv
verif/integer_to_roman_encoder_test.sv
